>>> rtl/mp2_pkg.sv
// Shared constants, types and codes for the 2x2 max pooling block.
package mp2_pkg;

  // Map limits
  localparam int MAX_ROWS     = 64;
  localparam int MAX_COLS     = 64;
  localparam int MAX_CHANNELS = 16;

  // Field widths
  localparam int CFG_W  = 7;
  localparam int CHAN_W = 4;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 16;
  localparam int ARG_W  = 2;

  // Pooled sizes and index store geometry
  localparam int HALF_ROWS   = MAX_ROWS / 2;
  localparam int HALF_COLS   = MAX_COLS / 2;
  localparam int HROW_W      = $clog2(HALF_ROWS);
  localparam int HCOL_W      = $clog2(HALF_COLS);
  localparam int STORE_DEPTH = MAX_CHANNELS * HALF_ROWS * HALF_COLS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Stream packing
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;
  localparam int OUT_PAD_W = M_TDATA_W - (CHAN_W + 2 * POS_W + VAL_W + ARG_W);

  // Configuration registers
  localparam int                 CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 1'b1;
  localparam logic [CFG_W-1:0]   MAP_RESET    = 7'd28;

  // Operation and result kinds
  localparam logic OP_FWD   = 1'b0;
  localparam logic OP_BWD   = 1'b1;
  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_BWD = 1'b1;

  // Window positions
  localparam logic [ARG_W-1:0] POS_TL = 2'd0;
  localparam logic [ARG_W-1:0] POS_TR = 2'd1;
  localparam logic [ARG_W-1:0] POS_BL = 2'd2;
  localparam logic [ARG_W-1:0] POS_BR = 2'd3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [VAL_W-1:0] value_t;

  // Class of an accepted item, set at the input
  typedef enum logic [2:0] {
    K_DROP,
    K_HOLD,
    K_PAIR,
    K_WIN,
    K_BWD
  } item_kind_t;

  // One queued job for the back part
  typedef struct packed {
    logic              bwd;
    logic [CHAN_W-1:0] chan;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    value_t            value;
    logic [ARG_W-1:0]  arg;
  } q_entry_t;

endpackage

>>> rtl/mp2_front.sv
// Front part: config registers, item classification, pooling and argmax store.
module mp2_front import mp2_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output q_entry_t             q_entry
);

  logic [CFG_W-1:0] map_rows;
  logic [CFG_W-1:0] map_cols;

  // Input field split
  logic [CHAN_W-1:0] in_chan;
  logic [POS_W-1:0]  in_row;
  logic [POS_W-1:0]  in_col;
  value_t            in_sample;

  logic [CFG_W-1:0] eff_rows;
  logic [CFG_W-1:0] eff_cols;
  logic [POS_W-1:0] p_rows;
  logic [POS_W-1:0] p_cols;
  item_kind_t       in_kind;

  // Stage 1: classified item
  logic              s1_v;
  item_kind_t        s1_kind;
  logic [CHAN_W-1:0] s1_chan;
  logic [POS_W-1:0]  s1_row;
  logic [POS_W-1:0]  s1_col;
  value_t            s1_sample;

  // Stage 2: job ready for the queue
  logic              s2_v;
  logic              s2_bwd;
  logic [CHAN_W-1:0] s2_chan;
  logic [POS_W-1:0]  s2_row;
  logic [POS_W-1:0]  s2_col;
  value_t            s2_value;
  logic [ARG_W-1:0]  s2_pos;
  logic [ARG_W-1:0]  idx_rd;

  // Pooling state
  value_t      line_max [HALF_COLS];
  logic        line_arg [HALF_COLS];
  value_t      pair_hold;
  logic [ARG_W-1:0] index_store [STORE_DEPTH];

  logic              adv;
  logic [HCOL_W-1:0] lb_idx;
  value_t            lb_max;
  logic              lb_arg;
  logic              pair_gt;
  logic              hold_gt;
  logic              last_gt;
  value_t            best1;
  logic [ARG_W-1:0]  pos1;
  value_t            best;
  logic [ARG_W-1:0]  pos;
  logic [STORE_AW-1:0] wr_addr;
  logic [STORE_AW-1:0] rd_addr;

  // Advance the pipeline whenever stage 2 can drain
  assign adv      = !s2_v || !q_full;
  assign s_tready = adv;
  assign q_push   = s2_v && !q_full;

  assign in_chan   = s_tdata[CHAN_W-1:0];
  assign in_row    = s_tdata[CHAN_W +: POS_W];
  assign in_col    = s_tdata[CHAN_W+POS_W +: POS_W];
  assign in_sample = s_tdata[CHAN_W+2*POS_W +: VAL_W];

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows <= MAP_RESET;
      map_cols <= MAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_ROWS: map_rows <= cfg_data;
        REG_MAP_COLS: map_cols <= cfg_data;
      endcase
    end
  end

  // Pooled map size
  assign eff_rows = (map_rows < CFG_W'(MAX_ROWS)) ? map_rows : CFG_W'(MAX_ROWS);
  assign eff_cols = (map_cols < CFG_W'(MAX_COLS)) ? map_cols : CFG_W'(MAX_COLS);
  assign p_rows   = eff_rows[CFG_W-1:1];
  assign p_cols   = eff_cols[CFG_W-1:1];

  // Classify the incoming item
  always_comb begin
    in_kind = K_DROP;
    if ({1'b0, in_chan} < (CHAN_W+1)'(MAX_CHANNELS)) begin
      if (s_tuser == OP_FWD) begin
        if (({1'b0, in_row[POS_W-1:1]} < p_rows) && ({1'b0, in_col[POS_W-1:1]} < p_cols)) begin
          if (!in_col[0]) begin
            in_kind = K_HOLD;
          end else if (!in_row[0]) begin
            in_kind = K_PAIR;
          end else begin
            in_kind = K_WIN;
          end
        end
      end else if ((in_row < p_rows) && (in_col < p_cols)) begin
        in_kind = K_BWD;
      end
    end
  end

  // Stage 1 load
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= s_tvalid && (in_kind != K_DROP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind   <= in_kind;
      s1_chan   <= in_chan;
      s1_row    <= in_row;
      s1_col    <= in_col;
      s1_sample <= in_sample;
    end
  end

  // Window compare: kept pair, then bottom-left, then bottom-right
  assign lb_idx  = s1_col[HCOL_W:1];
  assign lb_max  = line_max[lb_idx];
  assign lb_arg  = line_arg[lb_idx];
  assign pair_gt = s1_sample > pair_hold;
  assign hold_gt = pair_hold > lb_max;
  assign best1   = hold_gt ? pair_hold : lb_max;
  assign pos1    = hold_gt ? POS_BL : {1'b0, lb_arg};
  assign last_gt = s1_sample > best1;
  assign best    = last_gt ? s1_sample : best1;
  assign pos     = last_gt ? POS_BR : pos1;

  assign wr_addr = {s1_chan, s1_row[HROW_W:1], s1_col[HCOL_W:1]};
  assign rd_addr = {s1_chan, s1_row[HROW_W-1:0], s1_col[HCOL_W-1:0]};

  // Hold the even-column pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_hold <= '0;
    end else if (adv && s1_v && (s1_kind == K_HOLD)) begin
      pair_hold <= s1_sample;
    end
  end

  // Line buffer of even-row pair maxima
  always_ff @(posedge clk) begin
    if (adv && s1_v && (s1_kind == K_PAIR)) begin
      line_max[lb_idx] <= pair_gt ? s1_sample : pair_hold;
      line_arg[lb_idx] <= pair_gt;
    end
  end

  // Argmax store: write on a finished window, read for a gradient
  always_ff @(posedge clk) begin
    if (adv && s1_v && (s1_kind == K_WIN)) begin
      index_store[wr_addr] <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_rd <= index_store[rd_addr];
    end
  end

  // Stage 2 load
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v && ((s1_kind == K_WIN) || (s1_kind == K_BWD));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_bwd  <= (s1_kind == K_BWD);
      s2_chan <= s1_chan;
      s2_pos  <= pos;
      if (s1_kind == K_BWD) begin
        s2_row   <= s1_row;
        s2_col   <= s1_col;
        s2_value <= s1_sample;
      end else begin
        s2_row   <= {1'b0, s1_row[POS_W-1:1]};
        s2_col   <= {1'b0, s1_col[POS_W-1:1]};
        s2_value <= best;
      end
    end
  end

  // Job for the back part
  always_comb begin
    q_entry.bwd   = s2_bwd;
    q_entry.chan  = s2_chan;
    q_entry.row   = s2_row;
    q_entry.col   = s2_col;
    q_entry.value = s2_value;
    q_entry.arg   = s2_bwd ? idx_rd : s2_pos;
  end

endmodule

>>> rtl/mp2_queue.sv
// Short job queue between the front and back parts.
module mp2_queue import mp2_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/mp2_back.sv
// Back part: expands queued jobs into result items on the output register.
module mp2_back import mp2_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  q_entry_t             q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  logic [ARG_W-1:0] k;
  logic             load;
  logic             fin;
  logic [POS_W-1:0] o_row;
  logic [POS_W-1:0] o_col;
  value_t           o_value;
  logic [ARG_W-1:0] o_arg;

  // Output register takes a new item when empty or being taken
  assign load  = !m_tvalid || m_tready;
  assign fin   = !q_head.bwd || (k == POS_BR);
  assign q_pop = load && !q_empty && fin;

  // Build the current result item
  always_comb begin
    if (q_head.bwd) begin
      o_row   = POS_W'({q_head.row[HROW_W-1:0], k[1]});
      o_col   = POS_W'({q_head.col[HCOL_W-1:0], k[0]});
      o_value = (k == q_head.arg) ? q_head.value : '0;
      o_arg   = k;
    end else begin
      o_row   = q_head.row;
      o_col   = q_head.col;
      o_value = q_head.value;
      o_arg   = q_head.arg;
    end
  end

  // Step through the four block elements of a gradient
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (load && !q_empty && q_head.bwd) begin
      k <= fin ? '0 : k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      m_tdata <= {OUT_PAD_W'(0), o_arg, o_value, o_col, o_row, q_head.chan};
      m_tuser <= q_head.bwd ? KIND_BWD : KIND_FWD;
      m_tlast <= fin;
    end
  end

  // A gradient in progress stays at the queue head
  assert property (@(posedge clk) disable iff (rst)
    (k != '0) |-> (!q_empty && q_head.bwd))
    else $error("element counter running without a gradient at the head");

  // A pooled value is always the only result of its item
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_FWD)) |-> m_tlast)
    else $error("pooled result without last");

  // The final element of a gradient block is the bottom-right one
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_BWD) && m_tlast)
      |-> (m_tdata[CHAN_W+2*POS_W+VAL_W +: ARG_W] == POS_BR))
    else $error("gradient block closed on the wrong element");

endmodule

>>> rtl/maxpool_2x2_with_argmax_unpool_top.sv
// Top level of the 2x2 stride-2 max pooling block with argmax routing.
//
// Input stream s_*: one item per handshake; s_tuser is the operation (forward
// pixel or backward gradient), s_tdata carries chan, row, col and a Q8.8 sample.
// Forward pixels arrive in raster order per channel; the odd-row, odd-column
// pixel of each window yields one pooled value with its argmax position.
// A backward gradient yields four items, the 2x2 block in order tl, tr, bl, br,
// with the gradient at the stored argmax and zero elsewhere; tlast marks the
// final one. Items outside the configured map are dropped without a result.
// Each result passes stage 1, stage 2, the job queue and the output register.
// Throughput: one forward item per cycle while s_tready is high; a gradient's four
// result items share the single output register, while the four-entry job queue
// lets the input keep running until it fills. The user must write the map size
// through cfg_we/cfg_index/cfg_data while the block is idle; the block does not enforce it.
// Reset sets both map dimensions to 28 and empties the pipeline and queue; the
// argmax store and line buffer are not cleared and must be written before read.
// When m_tready is low the output item holds, the queue fills and then
// s_tready drops; nothing is lost.
module maxpool_2x2_with_argmax_unpool_top import mp2_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // chan, row_pos, col_pos, sample
  input  logic                 s_tuser,  // operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // out_chan, out_row, out_col, out_value, arg_pos, pad
  output logic                 m_tuser,  // result_kind
  output logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_in;
  q_entry_t q_head;

  mp2_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  mp2_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  mp2_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/sv/mp2_result_checker.sv
// Checker for the 2x2 max pooling block: tracks items in, predicts results, compares out.
module mp2_result_checker import mp2_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // chan, row_pos, col_pos, sample
  input  logic                 s_tuser,  // operation
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,  // out_chan, out_row, out_col, out_value, arg_pos, pad
  input  logic                 m_tuser,  // result_kind
  input  logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   outstanding,
  output int                   pooled_seen,
  output int                   grad_seen
);

  typedef struct {
    logic              kind;
    logic [CHAN_W-1:0] chan;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    value_t            value;
    logic [ARG_W-1:0]  arg;
    logic              last;
  } pool_result_t;

  // Own copy of the block's map size and storage
  logic [CFG_W-1:0] rows_q;
  logic [CFG_W-1:0] cols_q;
  value_t           row_pair_max [HALF_COLS];
  logic             row_pair_right [HALF_COLS];
  value_t           held_pixel;
  logic [ARG_W-1:0] argmax_mem [STORE_DEPTH];
  pool_result_t     awaited [$];

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Work out what one accepted item yields and update the copied state
  function automatic void pool_or_route(logic op, logic [CHAN_W-1:0] ch, logic [POS_W-1:0] r,
                                        logic [POS_W-1:0] c, value_t s);
    int           prows;
    int           pcols;
    int           slot;
    value_t       best;
    logic [ARG_W-1:0] pos;
    pool_result_t res;
    prows = ((int'(rows_q) < MAX_ROWS) ? int'(rows_q) : MAX_ROWS) / 2;
    pcols = ((int'(cols_q) < MAX_COLS) ? int'(cols_q) : MAX_COLS) / 2;
    if (op == OP_FWD) begin
      // drop pixels of a trailing row or column and anything off the map
      if (int'(r >> 1) >= prows || int'(c >> 1) >= pcols) return;
      if (!c[0]) begin
        held_pixel = s;
        return;
      end
      if (!r[0]) begin
        if (s > held_pixel) begin
          row_pair_max[c >> 1]   = s;
          row_pair_right[c >> 1] = 1'b1;
        end else begin
          row_pair_max[c >> 1]   = held_pixel;
          row_pair_right[c >> 1] = 1'b0;
        end
        return;
      end
      // window complete: top pair, then bottom-left, then bottom-right
      best = row_pair_max[c >> 1];
      pos  = row_pair_right[c >> 1] ? POS_TR : POS_TL;
      if (held_pixel > best) begin
        best = held_pixel;
        pos  = POS_BL;
      end
      if (s > best) begin
        best = s;
        pos  = POS_BR;
      end
      slot = (int'(ch) * HALF_ROWS + int'(r >> 1)) * HALF_COLS + int'(c >> 1);
      argmax_mem[slot] = pos;
      res.kind  = KIND_FWD;
      res.chan  = ch;
      res.row   = r >> 1;
      res.col   = c >> 1;
      res.value = best;
      res.arg   = pos;
      res.last  = 1'b1;
      awaited.push_back(res);
    end else begin
      if (int'(r) >= prows || int'(c) >= pcols) return;
      slot = (int'(ch) * HALF_ROWS + int'(r)) * HALF_COLS + int'(c);
      // emit the 2x2 block, gradient only at the stored argmax
      for (int k = 0; k < 4; k++) begin
        res.kind  = KIND_BWD;
        res.chan  = ch;
        res.row   = POS_W'(2 * r + k / 2);
        res.col   = POS_W'(2 * c + k % 2);
        res.arg   = k[ARG_W-1:0];
        res.value = (res.arg == argmax_mem[slot]) ? s : value_t'(0);
        res.last  = (res.arg == POS_BR);
        awaited.push_back(res);
      end
    end
  endfunction

  always @(posedge clk) begin
    pool_result_t want;
    if (rst) begin
      rows_q     = MAP_RESET;
      cols_q     = MAP_RESET;
      held_pixel = '0;
      awaited.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAP_ROWS) rows_q = cfg_data;
        else if (cfg_index == REG_MAP_COLS) cols_q = cfg_data;
      end
      if (s_tvalid && s_tready)
        pool_or_route(s_tuser, s_tdata[3:0], s_tdata[9:4], s_tdata[15:10], s_tdata[31:16]);
      // compare each result item with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, expected none, got tdata %h", $time, m_tdata);
        end else begin
          want = awaited.pop_front();
          check_field("result_kind", want.kind, m_tuser);
          check_field("out_chan", want.chan, m_tdata[3:0]);
          check_field("out_row", want.row, m_tdata[9:4]);
          check_field("out_col", want.col, m_tdata[15:10]);
          check_field("out_value", want.value, $signed(m_tdata[31:16]));
          check_field("arg_pos", want.arg, m_tdata[33:32]);
          check_field("last", want.last, m_tlast);
          if (want.kind == KIND_FWD) pooled_seen++;
          else grad_seen++;
        end
      end
    end
    outstanding = awaited.size();
  end

endmodule

>>> tb/sv/tb_maxpool_2x2_with_argmax_unpool_top.sv
// Testbench top for the 2x2 max pooling block: clock, reset, stimulus and verdict.
module tb_maxpool_2x2_with_argmax_unpool_top;
  import mp2_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 120;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // chan, row_pos, col_pos, sample
  logic                 s_tuser;   // operation
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // out_chan, out_row, out_col, out_value, arg_pos, pad
  logic                 m_tuser;   // result_kind
  logic                 m_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int errors;
  int outstanding;
  int pooled_seen;
  int grad_seen;
  int cycle_count;
  int items_sent;
  int settings_used;
  int cur_rows;
  int cur_cols;
  bit calm;
  bit hold_req;

  // Which line buffer slots and argmax cells hold written data
  bit line_ok [HALF_COLS];
  bit cell_ok [MAX_CHANNELS][HALF_ROWS][HALF_COLS];

  // Directed windows, tl tr bl br: all tied, top-right with later ties, bottom-left, bottom-right
  value_t dir_win [4][4] = '{'{-32768, -32768, -32768, -32768},
                             '{1, 32767, 32767, 32767},
                             '{-5, -6, 100, 100},
                             '{0, -1, -2, 32767}};

  maxpool_2x2_with_argmax_unpool_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mp2_result_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding),
    .pooled_seen(pooled_seen), .grad_seen(grad_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic value_t rand_sample();
    int pick;
    int near;
    pick = $urandom_range(0, 99);
    near = $urandom_range(0, 6);
    if (pick < 15) return value_t'(32767);
    if (pick < 30) return value_t'(-32768);
    if (pick < 55) return value_t'(near - 3);
    return value_t'($urandom());
  endfunction

  function automatic int pooled_rows();
    return ((cur_rows < MAX_ROWS) ? cur_rows : MAX_ROWS) / 2;
  endfunction

  function automatic int pooled_cols();
    return ((cur_cols < MAX_COLS) ? cur_cols : MAX_COLS) / 2;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall = pick_gap();
      end
    end
  end

  // Offer one item and hold it until taken; valid stays high for a back-to-back item
  task automatic send_item(logic op, int ch, int r, int c, value_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {v, c[POS_W-1:0], r[POS_W-1:0], ch[CHAN_W-1:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Forward pixel, noting which stores it fills
  task automatic send_pixel(int ch, int r, int c, value_t v);
    if ((r >> 1) < pooled_rows() && (c >> 1) < pooled_cols() && c % 2 == 1) begin
      if (r % 2 == 0) line_ok[c >> 1] = 1'b1;
      else cell_ok[ch][r >> 1][c >> 1] = 1'b1;
    end
    send_item(OP_FWD, ch, r, c, v);
  endtask

  // Drain all results, then let dropped items clear the pipeline
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_map(int rows, int cols);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAP_ROWS;
    cfg_data  <= rows[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_MAP_COLS;
    cfg_data  <= cols[CFG_W-1:0];
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_rows = rows;
    cur_cols = cols;
    settings_used++;
  endtask

  // Gradient for a pooled cell already written; returns 0 if none was found
  task automatic send_random_grad(output bit sent);
    int ch;
    int r;
    int c;
    sent = 1'b0;
    for (int t = 0; t < 16 && !sent; t++) begin
      ch = $urandom_range(0, MAX_CHANNELS - 1);
      r  = $urandom_range(0, pooled_rows() - 1);
      c  = $urandom_range(0, pooled_cols() - 1);
      if (cell_ok[ch][r][c]) begin
        send_item(OP_BWD, ch, r, c, rand_sample());
        sent = 1'b1;
      end
    end
  endtask

  // Raster stripe of whole windows on one pooled row
  task automatic send_stripe(output int count);
    int ch;
    int pr;
    int pc0;
    int n;
    ch    = $urandom_range(0, MAX_CHANNELS - 1);
    pr    = $urandom_range(0, pooled_rows() - 1);
    n     = $urandom_range(1, (pooled_cols() < 3) ? pooled_cols() : 3);
    pc0   = $urandom_range(0, pooled_cols() - n);
    count = 4 * n;
    for (int rr = 0; rr < 2; rr++)
      for (int cc = 2 * pc0; cc < 2 * (pc0 + n); cc++)
        send_pixel(ch, 2 * pr + rr, cc, rand_sample());
  endtask

  task automatic run_directed();
    set_map(3, 9);
    // two rows of four windows, column 8 trails
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 9; c++)
        send_pixel(5, r, c, (c == 8) ? value_t'(16'sh1234) : dir_win[c / 2][2 * r + c % 2]);
    // trailing row, then a row off the map
    send_pixel(5, 2, 3, 77);
    send_pixel(5, 40, 1, 77);
    send_item(OP_BWD, 5, 0, 0, 32767);
    send_item(OP_BWD, 5, 0, 1, -32768);
    send_item(OP_BWD, 5, 0, 2, -256);
    send_item(OP_BWD, 5, 0, 3, 256);
    // pooled cells off the map
    send_item(OP_BWD, 5, 1, 0, 99);
    send_item(OP_BWD, 5, 0, 4, 99);
  endtask

  task automatic run_phase(int rows, int cols, int target);
    int taken;
    int pick;
    int n;
    int ch;
    int r;
    int c;
    bit sent;
    set_map(rows, cols);
    taken = 0;
    while (taken < target) begin
      pick = $urandom_range(0, 99);
      ch   = $urandom_range(0, MAX_CHANNELS - 1);
      if (pick < 50) begin
        send_stripe(n);
        taken += n;
      end else if (pick < 80) begin
        send_random_grad(sent);
        if (sent) taken++;
      end else if (pick < 92) begin
        // stray pixel; never complete a window whose top pair is unwritten
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        if ((r >> 1) < pooled_rows() && (c >> 1) < pooled_cols() && r % 2 == 1 && c % 2 == 1
            && !line_ok[c >> 1])
          r--;
        send_pixel(ch, r, c, rand_sample());
      end else begin
        // gradient for a cell outside the pooled map
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(pooled_rows(), 63);
          c = $urandom_range(0, 63);
        end else begin
          r = $urandom_range(0, 63);
          c = $urandom_range(pooled_cols(), 63);
        end
        send_item(OP_BWD, ch, r, c, rand_sample());
      end
    end
  endtask

  // Hold the output off while gradients for the directed cells keep arriving, to fill the queue
  task automatic squeeze_output();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_item(OP_BWD, 5, 0, i % 4, rand_sample());
  endtask

  initial begin
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_FWD;
    cfg_we    = 1'b0;
    cfg_index = REG_MAP_ROWS;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    rst       = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    run_phase(64, 64, 14);
    squeeze_output();
    calm = 1'b1;
    run_phase(2, 2, 14);
    calm = 1'b0;
    run_phase(100, 7, 14);
    run_phase(17, 33, 14);
    wait_idle();

    $display("Run covered %0d items over %0d map settings, from 2x2 up to clamped 64-row maps,",
             items_sent, settings_used);
    $display("checking %0d pooled maxima and %0d gradient elements, with one long output stall.",
             pooled_seen, grad_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mp2_pkg.sv
rtl/mp2_front.sv
rtl/mp2_queue.sv
rtl/mp2_back.sv
rtl/maxpool_2x2_with_argmax_unpool_top.sv
tb/sv/mp2_result_checker.sv
tb/sv/tb_maxpool_2x2_with_argmax_unpool_top.sv
